// ===== rtl/core/bldef_pkg.sv =====
// Package for the button lockout debounce block with event queue.
// Holds the shared state type, command struct, opcodes and button masks.
// No dependencies.
`timescale 1ns / 1ps

package bldef_pkg;

    localparam int unsigned MASK_W   = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned WINDOW_W = 16;
    localparam int unsigned CODE_W   = 3;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd120;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    // Fixed GPIO line of each button; slots past the sixth never match.
    function automatic logic [MASK_W-1:0] button_mask(input int unsigned idx);
        logic [MASK_W-1:0] m;
        case (idx)
            0:       m = 16'h0008;
            1:       m = 16'h0010;
            2:       m = 16'h0020;
            3:       m = 16'h0100;
            4:       m = 16'h0200;
            5:       m = 16'h0400;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/bldef_in_if.sv =====
// Input channel of the button lockout block: edge reports and pop requests.
// Depends on bldef_pkg for field widths.
`timescale 1ns / 1ps

interface bldef_in_if;
    import bldef_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [MASK_W-1:0]   pin_mask;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, output op, output pin_mask, output now_ms, input ready);
    modport sink   (input valid, input op, input pin_mask, input now_ms, output ready);
endinterface

// ===== rtl/core/bldef_out_if.sv =====
// Result channel of the button lockout block.
// Depends on bldef_pkg for field widths.
`timescale 1ns / 1ps

interface bldef_out_if;
    import bldef_pkg::*;

    logic              valid;
    logic              ready;
    logic              event_valid;
    logic [CODE_W-1:0] event_code;
    logic              press_accepted;
    logic              press_dropped_full;
    logic              press_ignored;

    modport source (output valid, output event_valid, output event_code,
                    output press_accepted, output press_dropped_full,
                    output press_ignored, input ready);
    modport sink   (input valid, input event_valid, input event_code,
                    input press_accepted, input press_dropped_full,
                    input press_ignored, output ready);
endinterface

// ===== rtl/core/bldef_cfg_if.sv =====
// Configuration write channel carrying the debounce window.
// Depends on bldef_pkg for the register width.
`timescale 1ns / 1ps

interface bldef_cfg_if;
    import bldef_pkg::*;

    logic                valid;
    logic                ready;
    logic [WINDOW_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/button_lockout_debounce_event_fifo_top.sv =====
// Top level of the button lockout debounce block with event queue.
// Depends on bldef_pkg, the three channel interfaces, bldef_ctrl and bldef_dpath.
`timescale 1ns / 1ps

// Usage:
// i_in carries one transaction per item: op 0 reports a falling edge with
// a pin mask and the millisecond time, op 1 pops the oldest queued event.
// o_out returns exactly one result transaction per input transaction, in
// order: the popped event, or the accept, drop or ignore flag of an edge.
// i_cfg writes the debounce window; it is always ready and should be
// written only while no item is in flight.
// Each item passes through capture at the accepting edge, a ring memory
// read at the read pointer, and commit into the output register. A new
// item is accepted in the cycle after the commit, so the block does not
// take a new item until the last one has committed; the fetch step is
// there for the registered read of the ring memory. The
// block holds one item at a time.
// When the receiver stalls, the result waits in the output register; the
// next item is still taken and held at commit until the slot frees.
// Reset (synchronous, active low) empties the ring, clears all press times
// to zero and sets the window to 120 ms; ring contents need no clearing.

module button_lockout_debounce_event_fifo_top
    import bldef_pkg::*;
#(
    parameter int unsigned RING_DEPTH   = 16,
    parameter int unsigned BUTTON_COUNT = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bldef_in_if.sink    i_in,
    bldef_out_if.source o_out,
    bldef_cfg_if.sink   i_cfg
);

    t_cmd cmd;
    logic in_ready;
    logic out_valid;

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign i_cfg.ready = 1'b1;

    bldef_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    bldef_dpath #(
        .RING_DEPTH   (RING_DEPTH),
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_op                 (i_in.op),
        .i_pin_mask           (i_in.pin_mask),
        .i_now_ms             (i_in.now_ms),
        .i_cfg_we             (i_cfg.valid),
        .i_cfg_data           (i_cfg.data),
        .o_event_valid        (o_out.event_valid),
        .o_event_code         (o_out.event_code),
        .o_press_accepted     (o_out.press_accepted),
        .o_press_dropped_full (o_out.press_dropped_full),
        .o_press_ignored      (o_out.press_ignored)
    );

endmodule

// ===== rtl/core/bldef_ctrl.sv =====
// Controller of the button lockout block: sequences capture, memory fetch
// and commit, and owns the output register's valid flag. Uses bldef_pkg.
`timescale 1ns / 1ps

module bldef_ctrl
    import bldef_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                // The result may only be written once the output slot is free.
                o_cmd.commit = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/bldef_dpath.sv =====
// Datapath of the button lockout block: button match, debounce compare,
// press time table, event ring memory and output register. Uses bldef_pkg.
`timescale 1ns / 1ps

module bldef_dpath
    import bldef_pkg::*;
#(
    parameter int unsigned RING_DEPTH   = 16,
    parameter int unsigned BUTTON_COUNT = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_op,
    input  logic [MASK_W-1:0]   i_pin_mask,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic                i_cfg_we,
    input  logic [WINDOW_W-1:0] i_cfg_data,
    output logic                o_event_valid,
    output logic [CODE_W-1:0]   o_event_code,
    output logic                o_press_accepted,
    output logic                o_press_dropped_full,
    output logic                o_press_ignored
);

    localparam int unsigned PTR_W = $clog2(RING_DEPTH);
    localparam int unsigned IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic                r_op;
    logic [MASK_W-1:0]   r_mask;
    logic [TIME_W-1:0]   r_now;
    logic [WINDOW_W-1:0] r_window;
    logic [PTR_W-1:0]    r_wp, n_wp;
    logic [PTR_W-1:0]    r_rp, n_rp;
    logic [TIME_W-1:0]   r_last [BUTTON_COUNT];
    logic [CODE_W-1:0]   r_ring [RING_DEPTH];
    logic [CODE_W-1:0]   r_rd_data;

    logic                r_ev_valid, n_ev_valid;
    logic [CODE_W-1:0]   r_ev_code, n_ev_code;
    logic                r_acc, n_acc;
    logic                r_drop, n_drop;
    logic                r_ign, n_ign;

    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [TIME_W-1:0]   elapsed;
    logic                pass;
    logic [PTR_W-1:0]    wp_next;
    logic [PTR_W-1:0]    rp_next;
    logic                ring_full;
    logic                ring_empty;
    logic                time_we;
    logic                ring_we;

    // First button whose fixed mask equals the reported mask exactly.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int unsigned i = 0; i < BUTTON_COUNT; i++) begin
            if (!hit && button_mask(i) != '0 && button_mask(i) == r_mask) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // Modulo-2^32 elapsed time since the button's last accepted press.
    assign elapsed    = r_now - r_last[hit_idx];
    assign pass       = elapsed >= {{(TIME_W-WINDOW_W){1'b0}}, r_window};
    assign wp_next    = (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
    assign rp_next    = (r_rp == PTR_LAST) ? '0 : r_rp + PTR_W'(1);
    assign ring_full  = wp_next == r_rp;
    assign ring_empty = r_wp == r_rp;

    always_comb begin
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_ev_valid = 1'b0;
        n_ev_code  = '0;
        n_acc      = 1'b0;
        n_drop     = 1'b0;
        n_ign      = 1'b0;
        time_we    = 1'b0;
        ring_we    = 1'b0;
        if (r_op == OP_POP) begin
            if (!ring_empty) begin
                n_ev_valid = 1'b1;
                n_ev_code  = r_rd_data;
                n_rp       = rp_next;
            end
        end else if (!hit || !pass) begin
            n_ign = 1'b1;
        end else begin
            // The press time is refreshed even when the event is dropped.
            time_we = 1'b1;
            if (!ring_full) begin
                ring_we = 1'b1;
                n_wp    = wp_next;
                n_acc   = 1'b1;
            end else begin
                n_drop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_mask <= i_pin_mask;
            r_now  <= i_now_ms;
        end
        if (i_cmd.commit) begin
            r_ev_valid <= n_ev_valid;
            r_ev_code  <= n_ev_code;
            r_acc      <= n_acc;
            r_drop     <= n_drop;
            r_ign      <= n_ign;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_wp     <= '0;
            r_rp     <= '0;
            for (int unsigned i = 0; i < BUTTON_COUNT; i++) begin
                r_last[i] <= '0;
            end
        end else begin
            if (i_cfg_we) r_window <= i_cfg_data;
            if (i_cmd.commit) begin
                r_wp <= n_wp;
                r_rp <= n_rp;
                if (time_we) r_last[hit_idx] <= r_now;
            end
        end
    end

    // Event ring memory: one write port, one registered read at the read pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && ring_we) begin
            r_ring[r_wp] <= CODE_W'(hit_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_ring[r_rp];
    end

    assign o_event_valid        = r_ev_valid;
    assign o_event_code         = r_ev_code;
    assign o_press_accepted     = r_acc;
    assign o_press_dropped_full = r_drop;
    assign o_press_ignored      = r_ign;

endmodule

// ===== dv/button_lockout_debounce_event_fifo_top_tb.sv =====
// Self-checking testbench for button_lockout_debounce_event_fifo_top.
// A lockout predictor in a small class forecasts every result; it depends on
// bldef_pkg, the three channel interfaces and the top level RTL.
`timescale 1ns / 1ps

module button_lockout_debounce_event_fifo_top_tb;
    import bldef_pkg::*;

    localparam int unsigned GAP_MAX    = 17;
    localparam int unsigned SETTLE_CYC = 8;

    // GPIO line of each of the six buttons, in event code order.
    localparam logic [MASK_W-1:0] BTN_LINES [6] = '{
        16'h0008, 16'h0010, 16'h0020, 16'h0100, 16'h0200, 16'h0400
    };

    typedef struct packed {
        logic              event_valid;
        logic [CODE_W-1:0] event_code;
        logic              press_accepted;
        logic              press_dropped_full;
        logic              press_ignored;
    } outcome_t;

    // Tracks the debounce times and the event ring and forecasts each result.
    class lockout_predictor;
        logic [WINDOW_W-1:0] window;
        logic [CODE_W-1:0]   ring [16];
        logic [3:0]          wr_ptr;
        logic [3:0]          rd_ptr;
        logic [TIME_W-1:0]   last_press [6];
        outcome_t            outcomes [$];
        int unsigned         errors;

        function new();
            window = WINDOW_RESET;
            wr_ptr = '0;
            rd_ptr = '0;
            errors = 0;
            foreach (ring[i]) ring[i] = '0;
            foreach (last_press[i]) last_press[i] = '0;
        endfunction

        function void set_window(logic [WINDOW_W-1:0] w);
            window = w;
        endfunction

        function int unsigned pending();
            return outcomes.size();
        endfunction

        function void record_item(logic op, logic [MASK_W-1:0] mask,
                                  logic [TIME_W-1:0] now_ms);
            outcome_t          r;
            int                btn;
            logic [TIME_W-1:0] elapsed;
            logic [3:0]        wr_next;
            r   = '0;
            btn = -1;
            if (op == OP_POP) begin
                if (rd_ptr != wr_ptr) begin
                    r.event_valid = 1'b1;
                    r.event_code  = ring[rd_ptr];
                    rd_ptr        = rd_ptr + 4'd1;
                end
            end else begin
                for (int i = 0; i < 6; i++) begin
                    if (mask == BTN_LINES[i]) btn = i;
                end
                if (btn < 0) begin
                    r.press_ignored = 1'b1;
                end else begin
                    elapsed = now_ms - last_press[btn];
                    if (elapsed < {16'd0, window}) begin
                        r.press_ignored = 1'b1;
                    end else begin
                        // The press time is updated even when the ring is full.
                        last_press[btn] = now_ms;
                        wr_next = wr_ptr + 4'd1;
                        if (wr_next != rd_ptr) begin
                            ring[wr_ptr]     = btn[CODE_W-1:0];
                            wr_ptr           = wr_next;
                            r.press_accepted = 1'b1;
                        end else begin
                            r.press_dropped_full = 1'b1;
                        end
                    end
                end
            end
            outcomes.push_back(r);
        endfunction

        function void compare_outcome(outcome_t act);
            outcome_t exp_r;
            if (outcomes.size() == 0) begin
                $error("result transaction arrived with no expectation pending");
                errors++;
                return;
            end
            exp_r = outcomes.pop_front();
            if (act.event_valid !== exp_r.event_valid) begin
                $error("event_valid: expected %0d, actual %0d",
                       exp_r.event_valid, act.event_valid);
                errors++;
            end
            if (act.event_code !== exp_r.event_code) begin
                $error("event_code: expected %0d, actual %0d",
                       exp_r.event_code, act.event_code);
                errors++;
            end
            if (act.press_accepted !== exp_r.press_accepted) begin
                $error("press_accepted: expected %0d, actual %0d",
                       exp_r.press_accepted, act.press_accepted);
                errors++;
            end
            if (act.press_dropped_full !== exp_r.press_dropped_full) begin
                $error("press_dropped_full: expected %0d, actual %0d",
                       exp_r.press_dropped_full, act.press_dropped_full);
                errors++;
            end
            if (act.press_ignored !== exp_r.press_ignored) begin
                $error("press_ignored: expected %0d, actual %0d",
                       exp_r.press_ignored, act.press_ignored);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bldef_in_if  in_if ();
    bldef_out_if out_if ();
    bldef_cfg_if cfg_if ();

    button_lockout_debounce_event_fifo_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    lockout_predictor  lockout;
    logic              src_burst;
    logic              snk_burst;
    logic [TIME_W-1:0] clock_ms;
    int unsigned       cur_window;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(64'd6_000_000);
        $display("FAIL");
        $finish;
    end

    task automatic send_item(input logic op, input logic [MASK_W-1:0] mask,
                             input logic [TIME_W-1:0] now_ms);
        int unsigned gap;
        gap = src_burst ? 0 : $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 24) == 0) src_burst = ~src_burst;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.op       <= op;
        in_if.pin_mask <= mask;
        in_if.now_ms   <= now_ms;
        do @(posedge i_clk); while (!in_if.ready);
        lockout.record_item(op, mask, now_ms);
    endtask

    // Stops the input stream and waits for every outstanding result.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (lockout.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WINDOW_W-1:0] w);
        cfg_if.data  <= w;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        lockout.set_window(w);
        cur_window = w;
    endtask

    task automatic run_phase(input int unsigned n_items);
        int unsigned       pop_pct;
        int unsigned       sel;
        logic              op;
        logic [MASK_W-1:0] mask;
        pop_pct = 15;
        for (int unsigned k = 0; k < n_items; k++) begin
            // Every 40 items, pick at random between filling and emptying the ring.
            if (k % 40 == 0) pop_pct = $urandom_range(0, 1) ? 15 : 65;
            if (k == n_items / 2) drain();
            op  = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_EDGE;
            sel = $urandom_range(0, 99);
            if (op == OP_POP || sel >= 85) begin
                case ($urandom_range(0, 3))
                    0:       mask = '0;
                    1:       mask = 16'hFFFF;
                    2:       mask = 16'h0001 << $urandom_range(0, 15);
                    default: mask = 16'($urandom());
                endcase
            end else begin
                mask = BTN_LINES[$urandom_range(0, 5)];
            end
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                clock_ms = $urandom();
            end else if (sel < 7) begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, cur_window + 16);
            end else if (sel < 70) begin
                clock_ms = clock_ms + $urandom_range(0, cur_window / 4 + 3);
            end else begin
                clock_ms = clock_ms + $urandom_range(0, cur_window + cur_window / 2 + 2);
            end
            send_item(op, mask, clock_ms);
        end
    endtask

    initial begin
        outcome_t act;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            int unsigned gap;
            gap = snk_burst ? 0 : $urandom_range(0, GAP_MAX);
            if ($urandom_range(0, 24) == 0) snk_burst = ~snk_burst;
            if (gap != 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            act.event_valid        = out_if.event_valid;
            act.event_code         = out_if.event_code;
            act.press_accepted     = out_if.press_accepted;
            act.press_dropped_full = out_if.press_dropped_full;
            act.press_ignored      = out_if.press_ignored;
            lockout.compare_outcome(act);
        end
    end

    initial begin
        lockout        = new();
        src_burst      = 1'b0;
        snk_burst      = 1'b0;
        clock_ms       = '0;
        cur_window     = WINDOW_RESET;
        i_rst_n       <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.op       <= OP_EDGE;
        in_if.pin_mask <= '0;
        in_if.now_ms   <= '0;
        out_if.ready   <= 1'b0;
        cfg_if.valid   <= 1'b0;
        cfg_if.data    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, window at its reset value of 120 ms.
        send_item(OP_POP, '0, 32'd0);
        send_item(OP_EDGE, BTN_LINES[0], 32'd50);
        send_item(OP_EDGE, 16'h0000, 32'd500);
        send_item(OP_EDGE, 16'h0018, 32'd500);
        send_item(OP_EDGE, 16'h0001, 32'd500);
        send_item(OP_EDGE, 16'hFFFF, 32'd500);
        for (int b = 0; b < 6; b++) send_item(OP_EDGE, BTN_LINES[b], 32'd120);
        send_item(OP_EDGE, BTN_LINES[0], 32'd239);
        send_item(OP_EDGE, BTN_LINES[0], 32'd240);
        for (int p = 0; p < 8; p++) send_item(OP_POP, 16'($urandom()), $urandom());
        // Time difference taken across the 32-bit wrap.
        send_item(OP_EDGE, BTN_LINES[1], 32'hFFFF_FFF0);
        send_item(OP_EDGE, BTN_LINES[1], 32'h0000_0060);
        send_item(OP_EDGE, BTN_LINES[1], 32'h0000_0068);
        drain();

        write_window(16'd0);
        run_phase(195);
        drain();
        write_window(16'hFFFF);
        run_phase(195);
        drain();
        write_window(16'd1);
        run_phase(195);
        drain();
        write_window(16'($urandom()));
        run_phase(195);
        drain();
        write_window(WINDOW_RESET);
        run_phase(195);
        drain();
        write_window(16'($urandom_range(2, 400)));
        run_phase(195);
        drain();
        write_window(16'hFFFF);
        run_phase(195);

        drain();
        repeat (20) @(posedge i_clk);
        if (lockout.errors == 0 && lockout.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bldef_pkg.sv
rtl/core/bldef_in_if.sv
rtl/core/bldef_out_if.sv
rtl/core/bldef_cfg_if.sv
rtl/core/bldef_ctrl.sv
rtl/core/bldef_dpath.sv
rtl/core/button_lockout_debounce_event_fifo_top.sv
dv/button_lockout_debounce_event_fifo_top_tb.sv
